// File: sv/mcr_pkg.sv
// shared types and constants of the midpoint circle rasterizer
package mcr_pkg;

  localparam int unsigned COORD_W    = 9;
  localparam int unsigned RADIUS_W   = 7;
  localparam int unsigned COLOUR_W   = 15;
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned ADDR_W     = 18;
  localparam int unsigned NUM_SLOTS  = 8;
  localparam int unsigned MAX_RADIUS = 79;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(240);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(160);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0]  center_row;
    logic [COORD_W-1:0]  center_col;
    logic [RADIUS_W-1:0] radius;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                mode;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr_slot0;
    logic [ADDR_W-1:0]    addr_slot1;
    logic [ADDR_W-1:0]    addr_slot2;
    logic [ADDR_W-1:0]    addr_slot3;
    logic [ADDR_W-1:0]    addr_slot4;
    logic [ADDR_W-1:0]    addr_slot5;
    logic [ADDR_W-1:0]    addr_slot6;
    logic [ADDR_W-1:0]    addr_slot7;
    logic [NUM_SLOTS-1:0] slot_valid;
    logic [COLOUR_W-1:0]  write_colour;
    logic                 last_step;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic init;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cont;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/mcr_ctrl.sv
// controller state machine of the midpoint circle rasterizer
module mcr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mcr_pkg::dp_status_t status_i,
  output mcr_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.init = 1'b1;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!status_i.cont) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    stall_d = (state_d != ST_IDLE);
  end

  // state and registered stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

// File: sv/mcr_datapath.sv
// stepping datapath and output register of the midpoint circle rasterizer
module mcr_datapath #(
  parameter int unsigned MaxRadius = mcr_pkg::MAX_RADIUS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcr_pkg::in_item_t             in_data_i,
  input  logic [mcr_pkg::DIM_W-1:0]     width_i,
  input  logic [mcr_pkg::DIM_W-1:0]     height_i,
  input  mcr_pkg::ctrl_cmd_t            cmd_i,
  output mcr_pkg::dp_status_t           status_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output mcr_pkg::out_item_t            out_data_o
);

  localparam int unsigned RadW  = $clog2(MaxRadius + 1);
  localparam int unsigned PW    = RadW + 4;
  localparam int unsigned RowW  = mcr_pkg::COORD_W + 2;
  localparam int unsigned AW    = mcr_pkg::ADDR_W;
  localparam int unsigned NS    = mcr_pkg::NUM_SLOTS;
  localparam logic [mcr_pkg::RADIUS_W-1:0] MaxRad = mcr_pkg::RADIUS_W'(MaxRadius);

  logic [mcr_pkg::COORD_W-1:0]  cr_q, cc_q;
  logic [RadW-1:0]              a_q, b_q;
  logic signed [PW-1:0]         p_q;
  logic [mcr_pkg::COLOUR_W-1:0] colour_q;
  logic                         half_q;
  logic [AW-1:0]                crw_q, aw_q, bw_q;
  logic                         out_valid_q;
  mcr_pkg::out_item_t           out_q, out_d;

  logic [mcr_pkg::RADIUS_W-1:0] rad_sat;
  logic [RadW:0]                a_nx, b_nx;
  logic                         p_le0;
  logic signed [PW-1:0]         a2, b2, p_nx;
  logic [AW-1:0]                w_ext, aw_nx, bw_nx;
  logic                         cont;
  logic [mcr_pkg::COORD_W+mcr_pkg::DIM_W-1:0] crw_full;
  logic [RadW+mcr_pkg::DIM_W-1:0]             aw_full;

  // radius saturation on capture
  assign rad_sat = (in_data_i.radius > MaxRad) ? MaxRad : in_data_i.radius;

  // one midpoint step ahead
  always_comb begin
    p_le0 = (p_q <= 0);
    b_nx  = {1'b0, b_q} + (RadW + 1)'(1);
    a_nx  = p_le0 ? {1'b0, a_q} : ({1'b0, a_q} - (RadW + 1)'(1));
    b2    = $signed({{(PW - RadW - 2){1'b0}}, b_nx, 1'b0});
    a2    = $signed({{(PW - RadW - 2){1'b0}}, a_nx, 1'b0});
    p_nx  = p_le0 ? (p_q + b2 + PW'(1)) : (p_q + b2 - a2 + PW'(1));
    w_ext = {{(AW - mcr_pkg::DIM_W){1'b0}}, width_i};
    aw_nx = p_le0 ? aw_q : (aw_q - w_ext);
    bw_nx = bw_q + w_ext;
    cont  = (a_q > b_q) && !(a_nx < b_nx);
  end

  // row base products
  assign crw_full = cr_q * width_i;
  assign aw_full  = a_q * width_i;

  // mirrored points, screen test, half-mode test, duplicate test, addresses
  always_comb begin
    logic signed [RowW-1:0] as, bs, crs, ccs;
    logic signed [RowW-1:0] dr [NS];
    logic signed [RowW-1:0] dc [NS];
    logic signed [RowW-1:0] row, col;
    logic [AW-1:0]          base [NS];
    logic [AW-1:0]          addr [NS];
    logic [NS-1:0]          ok;
    as  = $signed({{(RowW - RadW){1'b0}}, a_q});
    bs  = $signed({{(RowW - RadW){1'b0}}, b_q});
    crs = $signed({2'b00, cr_q});
    ccs = $signed({2'b00, cc_q});
    dr[0] = as;  dc[0] = bs;
    dr[1] = -as; dc[1] = bs;
    dr[2] = as;  dc[2] = -bs;
    dr[3] = -as; dc[3] = -bs;
    dr[4] = bs;  dc[4] = as;
    dr[5] = -bs; dc[5] = as;
    dr[6] = bs;  dc[6] = -as;
    dr[7] = -bs; dc[7] = -as;
    base[0] = crw_q + aw_q; base[2] = crw_q + aw_q;
    base[1] = crw_q - aw_q; base[3] = crw_q - aw_q;
    base[4] = crw_q + bw_q; base[6] = crw_q + bw_q;
    base[5] = crw_q - bw_q; base[7] = crw_q - bw_q;
    for (int i = 0; i < NS; i++) begin
      row   = crs + dr[i];
      col   = ccs + dc[i];
      ok[i] = !row[RowW-1] && !col[RowW-1] &&
              ($unsigned(row) < {1'b0, height_i}) &&
              ($unsigned(col) < {1'b0, width_i});
      if (half_q && dr[i][RowW-1]) begin
        ok[i] = 1'b0;
      end
      for (int j = 0; j < NS; j++) begin
        if (j < i && dr[j] == dr[i] && dc[j] == dc[i]) begin
          ok[i] = 1'b0;
        end
      end
      addr[i] = ok[i] ? (base[i] + {{(AW - RowW){1'b0}}, $unsigned(col)}) : '0;
    end
    out_d.addr_slot0   = addr[0];
    out_d.addr_slot1   = addr[1];
    out_d.addr_slot2   = addr[2];
    out_d.addr_slot3   = addr[3];
    out_d.addr_slot4   = addr[4];
    out_d.addr_slot5   = addr[5];
    out_d.addr_slot6   = addr[6];
    out_d.addr_slot7   = addr[7];
    out_d.slot_valid   = ok;
    out_d.write_colour = colour_q;
    out_d.last_step    = !cont;
  end

  // command and stepping registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cr_q     <= in_data_i.center_row;
      cc_q     <= in_data_i.center_col;
      a_q      <= rad_sat[RadW-1:0];
      b_q      <= '0;
      p_q      <= PW'(1) - $signed({{(PW - RadW){1'b0}}, rad_sat[RadW-1:0]});
      colour_q <= in_data_i.pixel_colour;
      half_q   <= in_data_i.mode;
    end else if (cmd_i.init) begin
      crw_q <= crw_full[AW-1:0];
      aw_q  <= {{(AW - RadW - mcr_pkg::DIM_W){1'b0}}, aw_full};
      bw_q  <= '0;
    end else if (cmd_i.emit) begin
      a_q  <= a_nx[RadW-1:0];
      b_q  <= b_nx[RadW-1:0];
      p_q  <= p_nx;
      aw_q <= aw_nx;
      bw_q <= bw_nx;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign status_o.cont     = cont;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// File: sv/midpoint_circle_rasterizer_unit.sv
// top level of the midpoint circle rasterizer
// One command (centre, radius, colour, mode) yields N result beats, N = 1 plus
// the number of midpoint steps (up to 56 at radius 79); each beat carries the
// eight mirrored frame-buffer addresses with a valid mask, and the final beat
// has last_step set. A command passes through an accept state, a state for the
// row-base multiplies, then a stepping state in which the single stepping
// datapath emits one result set per cycle while the output is not stalled. The
// user must write screen width and height through the config port only while
// no command is in flight; the block itself does not enforce this.
module midpoint_circle_rasterizer_unit #(
  parameter int unsigned MaxRadius = mcr_pkg::MAX_RADIUS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mcr_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mcr_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mcr_pkg::DIM_W-1:0]     cfg_data_i
);

  logic [mcr_pkg::DIM_W-1:0] width_q, height_q;
  mcr_pkg::ctrl_cmd_t        cmd;
  mcr_pkg::dp_status_t       status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mcr_pkg::RESET_WIDTH;
      height_q <= mcr_pkg::RESET_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mcr_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        mcr_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // controller
  mcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  mcr_datapath #(
    .MaxRadius (MaxRadius)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/mcr_checker.sv
// port-level assertions of the midpoint circle rasterizer and their bind
module mcr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input mcr_pkg::out_item_t            out_data_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // an accepted command makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // no result beat in the cycle right after a command is accepted, unless a stalled beat is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("result beat before row bases were loaded");

  // masked slots carry address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.slot_valid[0] || out_data_o.addr_slot0 == '0) &&
      (out_data_o.slot_valid[1] || out_data_o.addr_slot1 == '0) &&
      (out_data_o.slot_valid[2] || out_data_o.addr_slot2 == '0) &&
      (out_data_o.slot_valid[3] || out_data_o.addr_slot3 == '0) &&
      (out_data_o.slot_valid[4] || out_data_o.addr_slot4 == '0) &&
      (out_data_o.slot_valid[5] || out_data_o.addr_slot5 == '0) &&
      (out_data_o.slot_valid[6] || out_data_o.addr_slot6 == '0) &&
      (out_data_o.slot_valid[7] || out_data_o.addr_slot7 == '0))
    else $error("masked slot with nonzero address");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker u_mcr_checker (.*);
